// ----- rtl/square_interval_phase_accumulator_core_defines.svh -----
// Assertion macros shared by the accumulator RTL.
`ifndef SQUARE_INTERVAL_PHASE_ACCUMULATOR_CORE_DEFINES_SVH
`define SQUARE_INTERVAL_PHASE_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset
`define SIPA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication
`define SIPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SIPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIPA_ASSERT(label, expr, msg)
`define SIPA_ASSERT_IMPL(label, ante, cons, msg)
`define SIPA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/sipa_pkg.sv -----
// Shared constants and types of the square interval phase accumulator.
package sipa_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SUM_BITS       = 32;
    localparam int TOTAL_BITS     = 32;
    localparam int COUNT_BITS     = 16;
    localparam int LEN_BITS       = 16;
    localparam int OFFSET_BITS    = 4;
    localparam int SCALED_BITS    = 21;
    localparam int PIECE_BITS     = 4;
    localparam int BIN_BITS       = 2;
    localparam int NUM_BINS       = 4;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    // Twelve pieces per interval
    localparam logic [LEN_BITS-1:0]    PIECES     = LEN_BITS'(12);
    localparam logic [PIECE_BITS-1:0]  LAST_PIECE = PIECE_BITS'(11);
    localparam logic [OFFSET_BITS-1:0] MAX_OFFSET = OFFSET_BITS'(11);

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL_FRAMES = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUNDING_OFFSET = CFG_INDEX_BITS'(1);

    // Per-frame status from the interval tracker
    typedef struct packed {
        logic [BIN_BITS-1:0] bin;
        logic                last;
    } trk_t;

    // Totals of one phase bin
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum_a;
        logic [SUM_BITS-1:0]   sum_b;
        logic [SUM_BITS-1:0]   sum_c;
        logic [COUNT_BITS-1:0] count;
    } bin_tot_t;

    typedef bin_tot_t [NUM_BINS-1:0] bin_set_t;

endpackage

// ----- rtl/square_interval_phase_accumulator_core.sv -----
// Top level of the square interval phase accumulator.
// The report of an interval starts on m_valid the cycle after its last frame is
// taken and drains the bins one per cycle while m_ready is high, bin zero first.
// Throughput: one frame per cycle; the last frame of an interval waits only if
// the report buffer still holds the previous, undrained report.
// Reset: aresetn synchronous, active low; default settings, zero sums, counts and position.
module square_interval_phase_accumulator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sipa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sipa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0]    s_chan_a,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0]    s_chan_b,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0]    s_chan_c,
    input  logic                                s_clear_totals,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sipa_pkg::BIN_BITS-1:0]       m_bin_index,
    output logic [sipa_pkg::TOTAL_BITS-1:0]     m_total_a,
    output logic [sipa_pkg::TOTAL_BITS-1:0]     m_total_b,
    output logic [sipa_pkg::TOTAL_BITS-1:0]     m_total_c,
    output logic [sipa_pkg::COUNT_BITS-1:0]     m_frame_count,
    output logic                                m_final_bin
);
    import sipa_pkg::*;

    trk_t     trk;
    bin_set_t bins_next;
    logic     rep_free;
    logic     accept;

    // Stall only the closing frame while a report is still going out
    assign s_ready = !trk.last || rep_free;
    assign accept  = s_valid && s_ready;

    sipa_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .trk       (trk)
    );

    sipa_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .bin          (trk.bin),
        .chan_a       (s_chan_a),
        .chan_b       (s_chan_b),
        .chan_c       (s_chan_c),
        .clear_totals (s_clear_totals),
        .bins_next    (bins_next)
    );

    sipa_report u_report (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept && trk.last),
        .snapshot      (bins_next),
        .free          (rep_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_index   (m_bin_index),
        .m_total_a     (m_total_a),
        .m_total_b     (m_total_b),
        .m_total_c     (m_total_c),
        .m_frame_count (m_frame_count),
        .m_final_bin   (m_final_bin)
    );

endmodule

// ----- rtl/sipa_tracker.sv -----
// Interval position tracker: configuration registers and piece boundaries.
`include "square_interval_phase_accumulator_core_defines.svh"

module sipa_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sipa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sipa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                advance,
    output sipa_pkg::trk_t                      trk
);
    import sipa_pkg::*;

    logic [LEN_BITS-1:0]    interval_reg, interval_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LEN_BITS-1:0]    frame_pos_reg, frame_pos_next;
    logic [PIECE_BITS-1:0]  piece_reg, piece_next;
    logic [SCALED_BITS-1:0] boundary_reg, boundary_next;
    logic [SCALED_BITS-1:0] pos_scaled_reg, pos_scaled_next;

    logic                   restart;
    logic [LEN_BITS-1:0]    len_cur, len_new;
    logic [OFFSET_BITS-1:0] off_new;
    logic                   step_piece;
    logic [PIECE_BITS-1:0]  piece_eff;

    // Configuration writes; unknown indexes are dropped
    always_comb begin
        interval_next = interval_reg;
        offset_next   = offset_reg;
        restart       = 1'b0;
        if (cfg_we) begin
            if (cfg_index == REG_INTERVAL_FRAMES) begin
                interval_next = cfg_wdata[LEN_BITS-1:0];
                restart       = 1'b1;
            end else if (cfg_index == REG_ROUNDING_OFFSET) begin
                offset_next = cfg_wdata[OFFSET_BITS-1:0];
                restart     = 1'b1;
            end
        end
    end

    // Clamp length and offset to their usable ranges
    assign len_cur = (interval_reg < PIECES) ? PIECES : interval_reg;
    assign len_new = (interval_next < PIECES) ? PIECES : interval_next;
    assign off_new = (offset_next > MAX_OFFSET) ? MAX_OFFSET : offset_next;

    // Move to the next piece once the scaled position passes the boundary
    assign step_piece = (pos_scaled_reg > boundary_reg) && (piece_reg < LAST_PIECE);
    assign piece_eff  = step_piece ? piece_reg + PIECE_BITS'(1) : piece_reg;

    assign trk.bin  = piece_eff[BIN_BITS-1:0];
    assign trk.last = ({1'b0, frame_pos_reg} + (LEN_BITS+1)'(1)) >= {1'b0, len_cur};

    // Position state: restart on a write or at interval end, else advance
    always_comb begin
        frame_pos_next  = frame_pos_reg;
        piece_next      = piece_reg;
        boundary_next   = boundary_reg;
        pos_scaled_next = pos_scaled_reg;
        if (restart || (advance && trk.last)) begin
            frame_pos_next  = '0;
            piece_next      = '0;
            boundary_next   = SCALED_BITS'(off_new) + SCALED_BITS'(len_new);
            pos_scaled_next = SCALED_BITS'(PIECES);
        end else if (advance) begin
            frame_pos_next  = frame_pos_reg + LEN_BITS'(1);
            piece_next      = piece_eff;
            pos_scaled_next = pos_scaled_reg + SCALED_BITS'(PIECES);
            if (step_piece) begin
                boundary_next = boundary_reg + SCALED_BITS'(len_cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg   <= PIECES;
            offset_reg     <= '0;
            frame_pos_reg  <= '0;
            piece_reg      <= '0;
            boundary_reg   <= SCALED_BITS'(PIECES);
            pos_scaled_reg <= SCALED_BITS'(PIECES);
        end else begin
            interval_reg   <= interval_next;
            offset_reg     <= offset_next;
            frame_pos_reg  <= frame_pos_next;
            piece_reg      <= piece_next;
            boundary_reg   <= boundary_next;
            pos_scaled_reg <= pos_scaled_next;
        end
    end

    `SIPA_ASSERT(a_piece_range, piece_reg <= LAST_PIECE, "piece number beyond last piece")
    `SIPA_ASSERT(a_pos_in_interval, frame_pos_reg < len_cur, "frame position past interval")
    `SIPA_ASSERT_IMPL(a_scaled_tracks_pos, 1'b1,
        pos_scaled_reg == SCALED_BITS'(frame_pos_reg) * SCALED_BITS'(PIECES)
            + SCALED_BITS'(PIECES), "scaled position out of step")

endmodule

// ----- rtl/sipa_accum.sv -----
// Phase bin accumulators: three channel sums and a frame count per bin.
module sipa_accum (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic [sipa_pkg::BIN_BITS-1:0]    bin,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0] chan_a,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0] chan_b,
    input  logic [sipa_pkg::SAMPLE_BITS-1:0] chan_c,
    input  logic                             clear_totals,
    output sipa_pkg::bin_set_t               bins_next
);
    import sipa_pkg::*;

    bin_set_t            bins_reg;
    logic [SUM_BITS-1:0] wide_a, wide_b, wide_c;

    // Sign-extend the samples to the sum width
    assign wide_a = SUM_BITS'(signed'(chan_a));
    assign wide_b = SUM_BITS'(signed'(chan_b));
    assign wide_c = SUM_BITS'(signed'(chan_c));

    // Clear first, then add the frame into its bin
    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            bins_next[b] = clear_totals ? '0 : bins_reg[b];
            if (bin == BIN_BITS'(b)) begin
                bins_next[b].sum_a = bins_next[b].sum_a + wide_a;
                bins_next[b].sum_b = bins_next[b].sum_b + wide_b;
                bins_next[b].sum_c = bins_next[b].sum_c + wide_c;
                bins_next[b].count = bins_next[b].count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= '0;
        end else if (advance) begin
            bins_reg <= bins_next;
        end
    end

endmodule

// ----- rtl/sipa_report.sv -----
// Report buffer: holds a snapshot of the four bins and drains it one per beat.
`include "square_interval_phase_accumulator_core_defines.svh"

module sipa_report (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  sipa_pkg::bin_set_t              snapshot,
    output logic                            free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sipa_pkg::BIN_BITS-1:0]   m_bin_index,
    output logic [sipa_pkg::TOTAL_BITS-1:0] m_total_a,
    output logic [sipa_pkg::TOTAL_BITS-1:0] m_total_b,
    output logic [sipa_pkg::TOTAL_BITS-1:0] m_total_c,
    output logic [sipa_pkg::COUNT_BITS-1:0] m_frame_count,
    output logic                            m_final_bin
);
    import sipa_pkg::*;

    bin_set_t            entries_reg;
    logic                valid_reg, valid_next;
    logic [BIN_BITS-1:0] cnt_reg, cnt_next;
    logic                pop, pop_last;
    bin_tot_t            cur;

    assign pop      = valid_reg && m_ready;
    assign pop_last = pop && (cnt_reg == BIN_BITS'(NUM_BINS - 1));
    assign free     = !valid_reg || pop_last;

    // Advance through the bins; a new snapshot restarts at bin zero
    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (pop) begin
            cnt_next = cnt_reg + BIN_BITS'(1);
            if (pop_last) begin
                valid_next = 1'b0;
            end
        end
        if (load) begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the snapshot
    always_ff @(posedge aclk) begin
        if (load) begin
            entries_reg <= snapshot;
        end
    end

    assign cur           = entries_reg[cnt_reg];
    assign m_valid       = valid_reg;
    assign m_bin_index   = cnt_reg;
    assign m_total_a     = TOTAL_BITS'(cur.sum_a);
    assign m_total_b     = TOTAL_BITS'(cur.sum_b);
    assign m_total_c     = TOTAL_BITS'(cur.sum_c);
    assign m_frame_count = cur.count;
    assign m_final_bin   = (cnt_reg == BIN_BITS'(NUM_BINS - 1));

    `SIPA_ASSERT_IMPL(a_no_overwrite, load && valid_reg, pop_last,
        "snapshot loaded over an undrained report")
    `SIPA_ASSERT_NEXT(a_load_starts, load, valid_reg && (cnt_reg == '0),
        "report does not start at bin zero")
    `SIPA_ASSERT_IMPL(a_idle_count, !valid_reg, cnt_reg == '0,
        "bin counter moved while idle")

endmodule

// ----- verif/square_interval_phase_accumulator_core_test.sv -----
// Self-checking testbench of the square interval phase accumulator core.
module square_interval_phase_accumulator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sipa_pkg::*;

    // Register indexes outside the register map; writes to them must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LOW  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = '1;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_FRAMES = 40;
    localparam int LONG_FRAMES   = 6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] chan_a;
        logic [SAMPLE_BITS-1:0] chan_b;
        logic [SAMPLE_BITS-1:0] chan_c;
        logic                   clear_totals;
    } frame_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin_index;
        logic [TOTAL_BITS-1:0] total_a;
        logic [TOTAL_BITS-1:0] total_b;
        logic [TOTAL_BITS-1:0] total_c;
        logic [COUNT_BITS-1:0] frame_count;
        logic                  final_bin;
    } bin_report_t;

    typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_mode_t;

    logic                      aclk;
    logic                      aresetn        = 1'b0;
    logic                      cfg_we         = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata      = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [SAMPLE_BITS-1:0]    s_chan_a       = '0;
    logic [SAMPLE_BITS-1:0]    s_chan_b       = '0;
    logic [SAMPLE_BITS-1:0]    s_chan_c       = '0;
    logic                      s_clear_totals = 1'b0;
    logic                      m_valid;
    logic                      m_ready        = 1'b1;
    logic [BIN_BITS-1:0]       m_bin_index;
    logic [TOTAL_BITS-1:0]     m_total_a;
    logic [TOTAL_BITS-1:0]     m_total_b;
    logic [TOTAL_BITS-1:0]     m_total_c;
    logic [COUNT_BITS-1:0]     m_frame_count;
    logic                      m_final_bin;

    // Pending frames, expected bin reports and bookkeeping
    frame_t      frame_queue[$];
    bin_report_t totals_expected[$];
    frame_t      current_frame;
    int          frames_queued   = 0;
    int          frames_taken    = 0;
    int          reports_checked = 0;
    int          mismatches      = 0;
    int          writes_done     = 0;
    int          clears_sent     = 0;
    bit          hold_request    = 1'b0;

    // Predicted configuration and interval position
    logic [LEN_BITS-1:0]    set_frames;
    logic [OFFSET_BITS-1:0] set_offset;
    logic [LEN_BITS-1:0]    frame_pos;
    logic [PIECE_BITS-1:0]  piece;
    logic [SCALED_BITS-1:0] boundary_x12;
    logic [SCALED_BITS-1:0] pos_x12;
    logic [SUM_BITS-1:0]    sum_a [NUM_BINS];
    logic [SUM_BITS-1:0]    sum_b [NUM_BINS];
    logic [SUM_BITS-1:0]    sum_c [NUM_BINS];
    logic [COUNT_BITS-1:0]  frames_in_bin [NUM_BINS];

    square_interval_phase_accumulator_core i_dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #50ms;
        $display("square_interval_phase_accumulator_core_test NOT OK");
        $finish;
    end

    // Short intervals count as twelve frames
    function automatic logic [LEN_BITS-1:0] interval_length();
        return (set_frames < PIECES) ? PIECES : set_frames;
    endfunction

    function automatic void clear_predicted_totals();
        for (int k = 0; k < NUM_BINS; k++) begin
            sum_a[k]         = '0;
            sum_b[k]         = '0;
            sum_c[k]         = '0;
            frames_in_bin[k] = '0;
        end
    endfunction

    // Go back to the first piece of a fresh interval
    function automatic void rewind_interval();
        logic [OFFSET_BITS-1:0] offset;
        offset       = (set_offset > MAX_OFFSET) ? MAX_OFFSET : set_offset;
        frame_pos    = '0;
        piece        = '0;
        boundary_x12 = SCALED_BITS'(offset) + SCALED_BITS'(interval_length());
        pos_x12      = SCALED_BITS'(PIECES);
    endfunction

    // Add one frame to its phase bin; at interval end queue the four bin reports
    function automatic void predict_frame(input frame_t f);
        logic [LEN_BITS-1:0] len;
        logic [BIN_BITS-1:0] b;
        bin_report_t         r;
        len = interval_length();
        if (f.clear_totals)
            clear_predicted_totals();
        if (pos_x12 > boundary_x12 && piece < LAST_PIECE) begin
            piece        = piece + 1'b1;
            boundary_x12 = boundary_x12 + SCALED_BITS'(len);
        end
        b                = piece[BIN_BITS-1:0];
        sum_a[b]         = sum_a[b] + SUM_BITS'(signed'(f.chan_a));
        sum_b[b]         = sum_b[b] + SUM_BITS'(signed'(f.chan_b));
        sum_c[b]         = sum_c[b] + SUM_BITS'(signed'(f.chan_c));
        frames_in_bin[b] = frames_in_bin[b] + 1'b1;
        if ({1'b0, frame_pos} + 1'b1 >= {1'b0, len}) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r.bin_index   = BIN_BITS'(k);
                r.total_a     = TOTAL_BITS'(sum_a[k]);
                r.total_b     = TOTAL_BITS'(sum_b[k]);
                r.total_c     = TOTAL_BITS'(sum_c[k]);
                r.frame_count = frames_in_bin[k];
                r.final_bin   = (k == NUM_BINS - 1);
                totals_expected.push_back(r);
            end
            rewind_interval();
        end else begin
            frame_pos = frame_pos + 1'b1;
            pos_x12   = pos_x12 + SCALED_BITS'(PIECES);
        end
    endfunction

    // Mostly uniform samples, with the extremes mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return '1;
            3:       return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void queue_frame(input logic [SAMPLE_BITS-1:0] a,
                                        input logic [SAMPLE_BITS-1:0] b,
                                        input logic [SAMPLE_BITS-1:0] c,
                                        input logic clr);
        frame_t f;
        f.chan_a       = a;
        f.chan_b       = b;
        f.chan_c       = c;
        f.clear_totals = clr;
        frame_queue.push_back(f);
        frames_queued++;
        if (clr)
            clears_sent++;
    endfunction

    function automatic void queue_random_frames(input int n, input int clear_odds);
        for (int i = 0; i < n; i++)
            queue_frame(pick_sample(), pick_sample(), pick_sample(),
                        $urandom_range(1, clear_odds) == 1);
    endfunction

    // Hold until every frame is taken and every report has arrived
    task automatic wait_idle();
        while (frames_taken != frames_queued || totals_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        writes_done++;
        if (idx == REG_INTERVAL_FRAMES) begin
            set_frames = data[LEN_BITS-1:0];
            rewind_interval();
        end else if (idx == REG_ROUNDING_OFFSET) begin
            set_offset = data[OFFSET_BITS-1:0];
            rewind_interval();
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Driver: offer frames in bursts, advance the predictor on each transaction
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_frame(current_frame);
                frames_taken++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (frame_queue.size() != 0) begin
                    current_frame  = frame_queue.pop_front();
                    s_chan_a       <= current_frame.chan_a;
                    s_chan_b       <= current_frame.chan_b;
                    s_chan_c       <= current_frame.chan_c;
                    s_clear_totals <= current_frame.clear_totals;
                    s_valid        <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus one long hold-off
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 64);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_HALF:   m_ready <= $urandom_range(0, 1);
                READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // Monitor: compare each result transaction with the oldest expected report
    always @(posedge aclk) begin
        bin_report_t seen;
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_bin_index, m_total_a, m_total_b, m_total_c, m_frame_count, m_final_bin};
            reports_checked++;
            if (totals_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("%0t: unexpected report, bin %0d a %h b %h c %h count %0d last %b",
                             $time, seen.bin_index, seen.total_a, seen.total_b,
                             seen.total_c, seen.frame_count, seen.final_bin);
            end else begin
                want = totals_expected.pop_front();
                if (seen != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED) begin
                        $display("%0t: report mismatch", $time);
                        $display("  expected bin %0d a %h b %h c %h count %0d last %b",
                                 want.bin_index, want.total_a, want.total_b,
                                 want.total_c, want.frame_count, want.final_bin);
                        $display("  actual   bin %0d a %h b %h c %h count %0d last %b",
                                 seen.bin_index, seen.total_a, seen.total_b,
                                 seen.total_c, seen.frame_count, seen.final_bin);
                    end
                end
            end
        end
    end

    // Stimulus: directed cases, random phases under several settings, a long interval cut short
    initial begin
        int                    random_frames;
        int                    len;
        logic [LEN_BITS-1:0]   frames_setting;
        set_frames = PIECES;
        set_offset = '0;
        clear_predicted_totals();
        rewind_interval();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: extremes of every channel, a clear at the start and mid-interval
        queue_frame(16'h7fff, 16'h8000, 16'h0000, 1'b1);
        queue_frame(16'h8000, 16'h7fff, 16'hffff, 1'b0);
        queue_frame(16'hffff, 16'h0001, 16'h8000, 1'b0);
        queue_frame(16'h0000, 16'hffff, 16'h7fff, 1'b0);
        queue_frame(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        queue_frame(16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_frame(16'h5555, 16'haaaa, 16'h0f0f, 1'b1);
        queue_random_frames(5, 4);
        wait_idle();

        // Short interval and oversized offset are clamped; spare indexes are dropped
        load_register(REG_INTERVAL_FRAMES, '0);
        load_register(REG_ROUNDING_OFFSET, '1);
        queue_random_frames(4, 8);
        wait_idle();
        load_register(REG_SPARE_LOW, 16'ha5a5);
        load_register(REG_SPARE_HIGH, 16'h5a5a);
        queue_random_frames(8, 8);
        wait_idle();

        // A register write part-way through an interval starts it afresh
        load_register(REG_INTERVAL_FRAMES, CFG_DATA_BITS'(11));
        load_register(REG_ROUNDING_OFFSET, CFG_DATA_BITS'(5));
        queue_random_frames(3, 8);
        wait_idle();
        load_register(REG_ROUNDING_OFFSET, CFG_DATA_BITS'(2));

        // Random phases under changing settings
        random_frames = 0;
        while (random_frames < RANDOM_FRAMES) begin
            case ($urandom_range(0, 4))
                0:       frames_setting = PIECES;
                1:       frames_setting = LEN_BITS'($urandom_range(0, 11));
                2:       frames_setting = LEN_BITS'($urandom_range(13, 20));
                default: frames_setting = LEN_BITS'($urandom_range(12, 30));
            endcase
            wait_idle();
            load_register(REG_INTERVAL_FRAMES, CFG_DATA_BITS'(frames_setting));
            load_register(REG_ROUNDING_OFFSET, CFG_DATA_BITS'($urandom_range(0, 15)));
            len = interval_length();
            len = len * $urandom_range(1, 3) + $urandom_range(0, len - 1);
            queue_random_frames(len, 20);
            random_frames += len;
        end

        // Start of the longest interval, cut short by the next write
        wait_idle();
        load_register(REG_INTERVAL_FRAMES, '1);
        load_register(REG_ROUNDING_OFFSET, CFG_DATA_BITS'($urandom_range(0, 11)));
        queue_random_frames(LONG_FRAMES, 4);
        wait_idle();

        // Two shortest intervals under the long output hold-off, so the input stalls
        load_register(REG_INTERVAL_FRAMES, CFG_DATA_BITS'(PIECES));
        load_register(REG_ROUNDING_OFFSET, CFG_DATA_BITS'(MAX_OFFSET));
        hold_request = 1'b1;
        queue_random_frames(2 * PIECES, 6);
        wait_idle();

        $display("Run covered %0d frames, %0d bin reports, %0d register writes, %0d clears,",
                 frames_taken, reports_checked, writes_done, clears_sent);
        $display("interval lengths from clamped short up to a partial 65535 and a %0d-cycle %s",
                 HOLD_CYCLES, "output hold-off.");
        if (mismatches == 0) begin
            $display("square_interval_phase_accumulator_core_test OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("square_interval_phase_accumulator_core_test NOT OK");
        end
        $finish;
    end

endmodule
